// ===== sv/vtab_pkg.sv =====
// Package with the shared types, constants and helpers of the adjacency builder.
package vtab_pkg;

   localparam int MAX_NODES     = 1024;
   localparam int MAX_TRIANGLES = 2048;
   localparam int ADJ_DEPTH     = 3 * MAX_TRIANGLES;
   localparam int NODE_W        = $clog2(MAX_NODES);
   localparam int TRI_W         = $clog2(MAX_TRIANGLES);
   localparam int LOAD_W        = TRI_W + 1;
   localparam int ADJ_W         = $clog2(ADJ_DEPTH);
   localparam int CNT_W         = 13;
   localparam int CFG_W         = 11;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_NOT_BUILT = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic        func;
      logic [9:0]  corner_node_0;
      logic [9:0]  corner_node_1;
      logic [9:0]  corner_node_2;
      logic        last_triangle;
      logic [9:0]  query_node;
      logic [12:0] query_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] neighbour_count;
      logic [12:0] start_offset;
      logic [10:0] triangle_index;
      logic [1:0]  corner;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic clr_init;
      logic clr_step;
      logic load_resp;
      logic tri_write;
      logic cnt_rd;
      logic cnt_wr;
      logic pre_init;
      logic pre_rd;
      logic pre_wr;
      logic tri_rd;
      logic cur_rd;
      logic cur_wr;
      logic set_built;
      logic q_resp_pre;
      logic q_rd;
      logic q_resp_slot;
      logic q_adj_rd;
      logic q_resp_ok;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_query;
      logic last;
      logic built;
      logic range_bad;
      logic full;
      logic q_node_bad;
      logic q_slot_bad;
      logic idx_end;
      logic k_end;
      logic t_end;
      logic empty;
   } stat_type;

   // Picks one corner node out of a stored triangle word {c2, c1, c0}.
   function automatic logic [NODE_W-1:0] corner_sel(input logic [3*NODE_W-1:0] w,
                                                    input logic [1:0] k);
      logic [NODE_W-1:0] r;
      unique case (k)
         2'd0:    r = w[NODE_W-1:0];
         2'd1:    r = w[2*NODE_W-1:NODE_W];
         default: r = w[3*NODE_W-1:2*NODE_W];
      endcase
      return r;
   endfunction

endpackage

// ===== sv/vtab_ctrl.sv =====
// Controller state machine that sequences clear, load, build and query.
module vtab_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  vtab_pkg::stat_type stat,
   output vtab_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DEC, S_L_RD, S_L_WR, S_P_RD, S_P_WR,
      S_T_RD, S_C_RD, S_C_WR, S_Q_CHK, S_Q_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.idx_end) begin
               state_in = pend_ff ? S_DEC : S_IDLE;
               pend_in  = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            if (stat.is_query) begin
               if (!stat.built || stat.q_node_bad) begin
                  cmd.q_resp_pre = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.q_rd = 1'b1;
                  state_in = S_Q_CHK;
               end
            end else if (stat.built) begin
               // A load after a build starts over from empty counts.
               cmd.clr_init = 1'b1;
               pend_in      = 1'b1;
               state_in     = S_CLEAR;
            end else begin
               cmd.load_resp = 1'b1;
               if (stat.range_bad) begin
                  state_in = S_IDLE;
               end else if (stat.full) begin
                  if (stat.last) begin
                     cmd.pre_init = 1'b1;
                     state_in     = S_P_RD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  cmd.tri_write = 1'b1;
                  state_in      = S_L_RD;
               end
            end
         end
         S_L_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = S_L_WR;
         end
         S_L_WR: begin
            cmd.cnt_wr = 1'b1;
            if (!stat.k_end) begin
               state_in = S_L_RD;
            end else if (stat.last) begin
               cmd.pre_init = 1'b1;
               state_in     = S_P_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_P_RD: begin
            cmd.pre_rd = 1'b1;
            state_in   = S_P_WR;
         end
         S_P_WR: begin
            cmd.pre_wr = 1'b1;
            if (!stat.idx_end) begin
               state_in = S_P_RD;
            end else if (stat.empty) begin
               cmd.set_built = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_T_RD;
            end
         end
         S_T_RD: begin
            cmd.tri_rd = 1'b1;
            state_in   = S_C_RD;
         end
         S_C_RD: begin
            cmd.cur_rd = 1'b1;
            state_in   = S_C_WR;
         end
         S_C_WR: begin
            cmd.cur_wr = 1'b1;
            if (!stat.k_end) begin
               state_in = S_C_RD;
            end else if (stat.t_end) begin
               cmd.set_built = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_T_RD;
            end
         end
         S_Q_CHK: begin
            if (stat.q_slot_bad) begin
               cmd.q_resp_slot = 1'b1;
               state_in        = S_IDLE;
            end else begin
               cmd.q_adj_rd = 1'b1;
               state_in     = S_Q_OUT;
            end
         end
         S_Q_OUT: begin
            cmd.q_resp_ok = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register; reset begins with the clearing pass over the counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== sv/vtab_dp.sv =====
// Datapath with the triangle, count, offset, cursor and adjacency memories.
module vtab_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  vtab_pkg::req_type              req_word,
   input  logic                           csr_wr_en,
   input  logic [vtab_pkg::CFG_W-1:0]     csr_wr_data,
   input  vtab_pkg::cmd_type              cmd,
   output vtab_pkg::stat_type             stat,
   output logic                           rsp_valid,
   output vtab_pkg::rsp_type              rsp_word
);

   localparam int NW = vtab_pkg::NODE_W;
   localparam int TW = vtab_pkg::TRI_W;
   localparam int AW = vtab_pkg::ADJ_W;
   localparam int CW = vtab_pkg::CNT_W;

   logic [CW-1:0]  cnt_mem [vtab_pkg::MAX_NODES];
   logic [CW-1:0]  off_mem [vtab_pkg::MAX_NODES];
   logic [CW-1:0]  cur_mem [vtab_pkg::MAX_NODES];
   logic [3*NW-1:0] tri_mem [vtab_pkg::MAX_TRIANGLES];
   logic [TW+1:0]  adj_mem [vtab_pkg::ADJ_DEPTH];

   vtab_pkg::req_type            req_ff;
   logic [vtab_pkg::CFG_W-1:0]   cfg_ff;
   logic [NW-1:0]                idx_ff;
   logic [TW-1:0]                t_ff;
   logic [1:0]                   k_ff;
   logic [CW-1:0]                sum_ff;
   logic [vtab_pkg::LOAD_W-1:0]  loaded_ff;
   logic                         built_ff;
   logic [CW-1:0]                cnt_rd_ff, off_rd_ff, cur_rd_ff;
   logic [3*NW-1:0]              tri_rd_ff;
   logic [TW+1:0]                adj_rd_ff;
   logic                         rsp_valid_ff;
   vtab_pkg::rsp_type            rsp_ff, rsp_in;

   logic [vtab_pkg::CFG_W-1:0]   nc;
   logic [NW-1:0]                load_node, scat_node, cnt_addr;
   logic [AW-1:0]                adj_addr;

   // Node count in use, saturated to one through the node capacity.
   always_comb begin
      if (cfg_ff == '0) begin
         nc = vtab_pkg::CFG_W'(1);
      end else if (cfg_ff > vtab_pkg::CFG_W'(vtab_pkg::MAX_NODES)) begin
         nc = vtab_pkg::CFG_W'(vtab_pkg::MAX_NODES);
      end else begin
         nc = cfg_ff;
      end
   end

   assign load_node = vtab_pkg::corner_sel({req_ff.corner_node_2, req_ff.corner_node_1,
                                            req_ff.corner_node_0}, k_ff);
   assign scat_node = vtab_pkg::corner_sel(tri_rd_ff, k_ff);
   assign adj_addr  = AW'(off_rd_ff + CW'(req_ff.query_slot));

   // Count memory address: load corner, queried node, or the clear and prefix index.
   always_comb begin
      priority if (cmd.cnt_rd || cmd.cnt_wr) begin
         cnt_addr = load_node;
      end else if (cmd.q_rd) begin
         cnt_addr = req_ff.query_node;
      end else begin
         cnt_addr = idx_ff;
      end
   end

   // Status toward the controller.
   always_comb begin
      stat.is_query   = (req_ff.func == vtab_pkg::FUNC_QUERY);
      stat.last       = req_ff.last_triangle;
      stat.built      = built_ff;
      stat.range_bad  = ({1'b0, req_ff.corner_node_0} >= nc) ||
                        ({1'b0, req_ff.corner_node_1} >= nc) ||
                        ({1'b0, req_ff.corner_node_2} >= nc);
      stat.full       = (loaded_ff == vtab_pkg::LOAD_W'(vtab_pkg::MAX_TRIANGLES));
      stat.q_node_bad = ({1'b0, req_ff.query_node} >= nc);
      stat.q_slot_bad = (req_ff.query_slot >= cnt_rd_ff);
      stat.idx_end    = (idx_ff == NW'(vtab_pkg::MAX_NODES - 1));
      stat.k_end      = (k_ff == 2'd2);
      stat.t_end      = ({1'b0, t_ff} == loaded_ff - vtab_pkg::LOAD_W'(1));
      stat.empty      = (loaded_ff == '0);
   end

   // Count memory.
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         cnt_mem[cnt_addr] <= '0;
      end else if (cmd.cnt_wr) begin
         cnt_mem[cnt_addr] <= cnt_rd_ff + CW'(1);
      end
      if (cmd.cnt_rd || cmd.pre_rd || cmd.q_rd) begin
         cnt_rd_ff <= cnt_mem[cnt_addr];
      end
   end

   // Offset memory.
   always_ff @(posedge clock) begin
      if (cmd.pre_wr) begin
         off_mem[idx_ff] <= sum_ff;
      end
      if (cmd.q_rd) begin
         off_rd_ff <= off_mem[req_ff.query_node];
      end
   end

   // Fill cursor memory, seeded with the offsets.
   always_ff @(posedge clock) begin
      if (cmd.pre_wr) begin
         cur_mem[idx_ff] <= sum_ff;
      end else if (cmd.cur_wr) begin
         cur_mem[scat_node] <= cur_rd_ff + CW'(1);
      end
      if (cmd.cur_rd) begin
         cur_rd_ff <= cur_mem[scat_node];
      end
   end

   // Triangle memory.
   always_ff @(posedge clock) begin
      if (cmd.tri_write) begin
         tri_mem[loaded_ff[TW-1:0]] <= {req_ff.corner_node_2, req_ff.corner_node_1,
                                        req_ff.corner_node_0};
      end
      if (cmd.tri_rd) begin
         tri_rd_ff <= tri_mem[t_ff];
      end
   end

   // Adjacency memory holds triangle index and corner number.
   always_ff @(posedge clock) begin
      if (cmd.cur_wr) begin
         adj_mem[AW'(cur_rd_ff)] <= {t_ff, k_ff};
      end
      if (cmd.q_adj_rd) begin
         adj_rd_ff <= adj_mem[adj_addr];
      end
   end

   // Request word, counters and build flag.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      if (reset) begin
         cfg_ff    <= vtab_pkg::CFG_W'(vtab_pkg::MAX_NODES);
         idx_ff    <= '0;
         k_ff      <= '0;
         t_ff      <= '0;
         sum_ff    <= '0;
         loaded_ff <= '0;
         built_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (cmd.clr_init) begin
            idx_ff    <= '0;
            loaded_ff <= '0;
            built_ff  <= 1'b0;
         end
         if (cmd.clr_step) begin
            idx_ff <= idx_ff + NW'(1);
         end
         if (cmd.tri_write || cmd.tri_rd) begin
            k_ff <= '0;
         end
         if (cmd.cnt_wr) begin
            if (k_ff == 2'd2) begin
               k_ff      <= '0;
               loaded_ff <= loaded_ff + vtab_pkg::LOAD_W'(1);
            end else begin
               k_ff <= k_ff + 2'd1;
            end
         end
         if (cmd.pre_init) begin
            idx_ff <= '0;
            sum_ff <= '0;
            t_ff   <= '0;
         end
         if (cmd.pre_wr) begin
            idx_ff <= idx_ff + NW'(1);
            sum_ff <= sum_ff + cnt_rd_ff;
         end
         if (cmd.cur_wr) begin
            if (k_ff == 2'd2) begin
               k_ff <= '0;
               t_ff <= t_ff + TW'(1);
            end else begin
               k_ff <= k_ff + 2'd1;
            end
         end
         if (cmd.set_built) begin
            built_ff <= 1'b1;
         end
      end
   end

   // Result word for the answer that the controller asks for.
   always_comb begin
      rsp_in = '0;
      if (cmd.load_resp) begin
         priority if (stat.range_bad) begin
            rsp_in.status = vtab_pkg::ST_RANGE;
         end else if (stat.full) begin
            rsp_in.status = vtab_pkg::ST_FULL;
         end else begin
            rsp_in.status = vtab_pkg::ST_OK;
         end
      end else if (cmd.q_resp_pre) begin
         rsp_in.status = built_ff ? vtab_pkg::ST_RANGE : vtab_pkg::ST_NOT_BUILT;
      end else if (cmd.q_resp_slot) begin
         rsp_in.status          = vtab_pkg::ST_RANGE;
         rsp_in.neighbour_count = cnt_rd_ff;
         rsp_in.start_offset    = off_rd_ff;
      end else if (cmd.q_resp_ok) begin
         rsp_in.status          = vtab_pkg::ST_OK;
         rsp_in.neighbour_count = cnt_rd_ff;
         rsp_in.start_offset    = off_rd_ff;
         rsp_in.triangle_index  = adj_rd_ff[TW+1:2];
         rsp_in.corner          = adj_rd_ff[1:0];
      end
   end

   // Result word register and strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.load_resp || cmd.q_resp_pre || cmd.q_resp_slot ||
                         cmd.q_resp_ok;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== sv/vertex_triangle_adjacency_builder.sv =====
// Top level of the vertex-to-triangle adjacency builder.
// After reset the block clears its 1024 node counts with busy high; a load that follows
// a build runs the same clear first. A word is taken when start is high and busy is low.
// A load is answered from its decode state; an in-range load into a store that is not
// full then makes the three read-modify-write count updates through the one count memory
// port. A load marked last that is in range then runs the build: a prefix sum over all
// nodes, then a scatter of each stored triangle's corners through the cursor memory. A
// query answers from the decode state, the slot check or the adjacency read. Every answer
// is shown for exactly one cycle with rsp_valid and the receiver cannot hold it off.
module vertex_triangle_adjacency_builder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  vtab_pkg::req_type          req_word,
   output logic                       rsp_valid,
   output vtab_pkg::rsp_type          rsp_word,
   input  logic                       csr_wr_en,
   input  logic [vtab_pkg::CFG_W-1:0] csr_wr_data
);

   vtab_pkg::cmd_type  cmd;
   vtab_pkg::stat_type stat;

   vtab_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   vtab_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_word    (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

endmodule

// ===== sv/vtab_checker.sv =====
// Port-level checker for the adjacency builder, bound to the top level.
module vtab_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input vtab_pkg::rsp_type rsp_word
);

   // An accepted word keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted word did not raise busy");

   // Reset starts the clearing pass.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> busy) else $error("no clearing pass after reset");

   // One word gives one answer, never two in a row.
   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("answers back to back");

   // A query before the build reports nothing else.
   a_not_built_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == vtab_pkg::ST_NOT_BUILT |->
         rsp_word.neighbour_count == '0 && rsp_word.start_offset == '0)
      else $error("not-built answer carries data");

   // A full store answer comes from a load and carries no triangle.
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == vtab_pkg::ST_FULL |->
         rsp_word.triangle_index == '0 && rsp_word.corner == '0)
      else $error("store-full answer carries data");

endmodule

bind vertex_triangle_adjacency_builder vtab_port_checker u_vtab_port_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);

// ===== verif/vtab_checker.sv =====
// Checker for the adjacency builder: mirrors its state, predicts each answer and compares.
module vtab_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  vtab_pkg::req_type          req_word,
   input  logic                       rsp_valid,
   input  vtab_pkg::rsp_type          rsp_word,
   input  logic                       csr_wr_en,
   input  logic [vtab_pkg::CFG_W-1:0] csr_wr_data,
   output int                         error_count,
   output int                         answers_waiting
);

   // Mirror of the block's stores.
   logic [9:0]                 mesh_nodes [vtab_pkg::MAX_TRIANGLES][3];
   logic [12:0]                node_hits [vtab_pkg::MAX_NODES];
   logic [12:0]                node_base [vtab_pkg::MAX_NODES];
   logic [10:0]                adj_triangle [vtab_pkg::ADJ_DEPTH];
   logic [1:0]                 adj_corner [vtab_pkg::ADJ_DEPTH];
   int                         mesh_size;
   bit                         mesh_built;
   logic [vtab_pkg::CFG_W-1:0] node_limit_reg;
   vtab_pkg::rsp_type          expected_answers[$];

   // Counting sort over the stored triangles, in load order.
   task automatic build_lists();
      int sum;
      int pos;
      int fill [vtab_pkg::MAX_NODES];
      logic [9:0] nd;
      sum = 0;
      for (int n = 0; n < vtab_pkg::MAX_NODES; n++) begin
         node_base[n] = sum[12:0];
         fill[n] = 0;
         sum += int'(node_hits[n]);
      end
      for (int t = 0; t < mesh_size; t++) begin
         for (int c = 0; c < 3; c++) begin
            nd = mesh_nodes[t][c];
            pos = int'(node_base[nd]) + fill[nd];
            if (pos < vtab_pkg::ADJ_DEPTH) begin
               adj_triangle[pos] = t[10:0];
               adj_corner[pos] = c[1:0];
               fill[nd]++;
            end
         end
      end
      mesh_built = 1'b1;
   endtask

   // Works out the answer to one accepted word and updates the mirror.
   task automatic predict_answer(input vtab_pkg::req_type w, output vtab_pkg::rsp_type ans);
      int nodes_used;
      int cnt;
      int pos;
      ans = '0;
      nodes_used = (int'(node_limit_reg) < 1) ? 1
                   : (int'(node_limit_reg) > vtab_pkg::MAX_NODES) ? vtab_pkg::MAX_NODES
                   : int'(node_limit_reg);
      if (w.func == vtab_pkg::FUNC_LOAD) begin
         // A load after a build starts a fresh mesh.
         if (mesh_built) begin
            for (int n = 0; n < vtab_pkg::MAX_NODES; n++) node_hits[n] = '0;
            mesh_size = 0;
            mesh_built = 1'b0;
         end
         if (int'(w.corner_node_0) >= nodes_used || int'(w.corner_node_1) >= nodes_used ||
             int'(w.corner_node_2) >= nodes_used) begin
            ans.status = vtab_pkg::ST_RANGE;
         end else begin
            if (mesh_size >= vtab_pkg::MAX_TRIANGLES) begin
               ans.status = vtab_pkg::ST_FULL;
            end else begin
               mesh_nodes[mesh_size][0] = w.corner_node_0;
               mesh_nodes[mesh_size][1] = w.corner_node_1;
               mesh_nodes[mesh_size][2] = w.corner_node_2;
               mesh_size++;
               node_hits[w.corner_node_0]++;
               node_hits[w.corner_node_1]++;
               node_hits[w.corner_node_2]++;
            end
            if (w.last_triangle) build_lists();
         end
      end else begin
         if (!mesh_built) begin
            ans.status = vtab_pkg::ST_NOT_BUILT;
         end else if (int'(w.query_node) >= nodes_used) begin
            ans.status = vtab_pkg::ST_RANGE;
         end else begin
            cnt = int'(node_hits[w.query_node]);
            ans.neighbour_count = node_hits[w.query_node];
            ans.start_offset = node_base[w.query_node];
            if (int'(w.query_slot) >= cnt) begin
               ans.status = vtab_pkg::ST_RANGE;
            end else begin
               pos = int'(node_base[w.query_node]) + int'(w.query_slot);
               if (pos < vtab_pkg::ADJ_DEPTH) begin
                  ans.triangle_index = adj_triangle[pos];
                  ans.corner = adj_corner[pos];
               end else begin
                  ans.status = vtab_pkg::ST_RANGE;
               end
            end
         end
      end
   endtask

   task automatic report_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Sample both channels at every edge.
   always @(posedge clock) begin
      vtab_pkg::rsp_type exp_w;
      vtab_pkg::rsp_type pred;
      if (reset) begin
         for (int n = 0; n < vtab_pkg::MAX_NODES; n++) node_hits[n] = '0;
         mesh_size = 0;
         mesh_built = 1'b0;
         node_limit_reg = 11'd1024;
         expected_answers.delete();
         error_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: answer with none expected, actual %h", $time, rsp_word);
               error_count++;
            end else begin
               exp_w = expected_answers.pop_front();
               report_field("status", int'(exp_w.status), int'(rsp_word.status));
               report_field("neighbour_count", int'(exp_w.neighbour_count),
                            int'(rsp_word.neighbour_count));
               report_field("start_offset", int'(exp_w.start_offset),
                            int'(rsp_word.start_offset));
               report_field("triangle_index", int'(exp_w.triangle_index),
                            int'(rsp_word.triangle_index));
               report_field("corner", int'(exp_w.corner), int'(rsp_word.corner));
            end
         end
         if (start && !busy) begin
            predict_answer(req_word, pred);
            expected_answers.push_back(pred);
         end
         if (csr_wr_en) node_limit_reg = csr_wr_data;
      end
      answers_waiting = expected_answers.size();
   end

endmodule

// ===== verif/tb.sv =====
// Top of the adjacency builder testbench: clock, reset, stimulus and verdict.
module tb;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   vtab_pkg::req_type          req_word;
   logic                       rsp_valid;
   vtab_pkg::rsp_type          rsp_word;
   logic                       csr_wr_en;
   logic [vtab_pkg::CFG_W-1:0] csr_wr_data;
   int                         error_count;
   int                         answers_waiting;
   int                         words_sent;
   int                         quiet_cycles;
   int                         nodes_now;
   bit                         no_gaps;

   localparam int WATCHDOG_LIMIT = 60000;

   vertex_triangle_adjacency_builder dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   vtab_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data), .error_count(error_count),
      .answers_waiting(answers_waiting)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("vertex_triangle_adjacency_builder test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   // Presents one word and waits until it is taken, then idles for a gap.
   task automatic send_word(input vtab_pkg::req_type w);
      int gap;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_load(input int a, input int b, input int c, input bit last_t);
      vtab_pkg::req_type w;
      w = $bits(vtab_pkg::req_type)'({$urandom, $urandom});
      w.func = vtab_pkg::FUNC_LOAD;
      w.corner_node_0 = a[9:0];
      w.corner_node_1 = b[9:0];
      w.corner_node_2 = c[9:0];
      w.last_triangle = last_t;
      send_word(w);
   endtask

   task automatic send_query(input int n, input int s);
      vtab_pkg::req_type w;
      w = $bits(vtab_pkg::req_type)'({$urandom, $urandom});
      w.func = vtab_pkg::FUNC_QUERY;
      w.query_node = n[9:0];
      w.query_slot = s[12:0];
      send_word(w);
   endtask

   // Waits until every answer is in and the block is idle.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (answers_waiting != 0 || busy) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_node_limit(input int v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v[vtab_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      nodes_now = (v < 1) ? 1 : (v > vtab_pkg::MAX_NODES) ? vtab_pkg::MAX_NODES : v;
   endtask

   function automatic int node_in_use();
      return $urandom_range(0, nodes_now - 1);
   endfunction

   initial begin
      int tris;
      int queries;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      words_sent = 0;
      nodes_now = vtab_pkg::MAX_NODES;
      no_gaps = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Queries before any build.
      send_query(0, 0);
      send_query(1023, 8191);

      // Small mesh with range errors, then a build and edge queries.
      write_node_limit(4);
      send_load(0, 1, 2, 1'b0);
      send_load(3, 3, 3, 1'b0);
      send_load(4, 0, 0, 1'b1);
      send_load(1023, 1023, 1023, 1'b0);
      send_load(0, 2, 3, 1'b1);
      send_query(0, 0);
      send_query(0, 1);
      send_query(3, 3);
      send_query(3, 4);
      send_query(2, 1);
      send_query(4, 0);
      send_query(1023, 8191);
      // Shrink the node range after the build.
      write_node_limit(2);
      send_query(3, 0);
      send_query(1, 0);

      // Single node in use; a zero setting saturates to one.
      write_node_limit(0);
      send_load(0, 0, 0, 1'b0);
      send_load(0, 0, 1, 1'b0);
      send_load(0, 0, 0, 1'b1);
      send_query(0, 5);
      send_query(0, 6);
      send_query(1, 0);

      // Random meshes until enough words have gone in.
      while (words_sent < 1500) begin
         case ($urandom_range(0, 9))
            0: write_node_limit(vtab_pkg::MAX_NODES);
            1: write_node_limit($urandom_range(0, 2047));
            default: write_node_limit($urandom_range(1, 24));
         endcase
         no_gaps = ($urandom_range(0, 4) == 0);
         tris = $urandom_range(1, 40);
         for (int t = 0; t < tris; t++) begin
            if ($urandom_range(0, 19) == 0)
               send_query(node_in_use(), $urandom_range(0, 8191));
            if ($urandom_range(0, 9) == 0)
               send_load($urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
            else
               send_load(node_in_use(), node_in_use(), node_in_use(),
                         (t == tris - 1) || ($urandom_range(0, 29) == 0));
         end
         queries = $urandom_range(10, 60);
         for (int q = 0; q < queries; q++) begin
            if ($urandom_range(0, 9) == 0)
               send_query($urandom_range(0, 1023), $urandom_range(0, 8191));
            else
               send_query(node_in_use(), $urandom_range(0, 3 * tris / nodes_now + 3));
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && answers_waiting == 0)
         $display("vertex_triangle_adjacency_builder test passed");
      else
         $display("vertex_triangle_adjacency_builder test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/vtab_pkg.sv
sv/vtab_ctrl.sv
sv/vtab_dp.sv
sv/vertex_triangle_adjacency_builder.sv
sv/vtab_checker.sv
verif/vtab_checker.sv
verif/tb.sv
